// ===== rtl/kwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

    localparam int HEAP_SLOTS_DEF = 16;
    localparam int VALUE_W        = 32;
    localparam int STREAM_W       = 4;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STREAM_W-1:0]       stream;
    } entry_t;

    typedef enum logic [1:0] {
        RSP_POPPED   = 2'd0,
        RSP_INSERTED = 2'd1,
        RSP_EMPTY    = 2'd2,
        RSP_FULL     = 2'd3
    } rsp_t;

    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_POP    = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_LOAD,
        ST_SIFT_UP,
        ST_SIFT_DOWN,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_REJECT,
        OP_INS_START,
        OP_POP_START,
        OP_POP_LOAD,
        OP_UP_STEP,
        OP_DOWN_STEP
    } op_t;

    typedef struct packed {
        op_t  op;
        rsp_t rsp;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_pop;
        logic full;
        logic empty;
        logic up_done;
        logic down_done;
        logic out_free;
    } sts_t;

    // Signed value first, ties broken by the lower stream number.
    function automatic logic key_less(input entry_t a, input entry_t b);
        logic [VALUE_W+STREAM_W-1:0] ka;
        logic [VALUE_W+STREAM_W-1:0] kb;
        ka = {~a.value[VALUE_W-1], a.value[VALUE_W-2:0], a.stream};
        kb = {~b.value[VALUE_W-1], b.value[VALUE_W-2:0], b.stream};
        return ka < kb;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/k_way_merge_heap.sv =====
// An insert goes from ST_IDLE through ST_SIFT_UP to ST_RESP, a pop through ST_POP_LOAD
//   and ST_SIFT_DOWN; a sift moves d heap levels, d at most floor(log2(HEAP_SLOTS));
//   a pop that empties the heap skips it, and full/empty rejects go straight to ST_RESP.
// Throughput: one request at a time, the next accepted the cycle after the result
//   is registered; the sift walks one heap level per cycle on the 2-read heap RAM.
// Reset (aresetn, synchronous, active low) empties the heap and drops any pending
//   result; heap RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module k_way_merge_heap
    import kwm_pkg::*;
#(
    parameter int HEAP_SLOTS = HEAP_SLOTS_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire                        s_req_type,
    input  wire signed [VALUE_W-1:0]   s_element_value,
    input  wire [STREAM_W-1:0]         s_stream_id,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [1:0]                 m_status,
    output logic signed [VALUE_W-1:0]  m_out_value,
    output logic [STREAM_W-1:0]        m_out_stream,
    output logic                       m_now_empty
);

    cmd_t cmd;
    sts_t sts;

    kwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kwm_datapath #(
        .HEAP_SLOTS (HEAP_SLOTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_req_type      (s_req_type),
        .s_element_value (s_element_value),
        .s_stream_id     (s_stream_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_value     (m_out_value),
        .m_out_stream    (m_out_stream),
        .m_now_empty     (m_now_empty)
    );

endmodule

`default_nettype wire

// ===== rtl/kwm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwm_ctrl
    import kwm_pkg::*;
(
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.rsp      = RSP_POPPED;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (s_valid) begin
                    if (sts.in_pop) begin
                        if (sts.empty) begin
                            cmd.op     = OP_REJECT;
                            cmd.rsp    = RSP_EMPTY;
                            state_next = ST_RESP;
                        end else begin
                            cmd.op     = OP_POP_START;
                            cmd.rsp    = RSP_POPPED;
                            state_next = ST_POP_LOAD;
                        end
                    end else begin
                        if (sts.full) begin
                            cmd.op     = OP_REJECT;
                            cmd.rsp    = RSP_FULL;
                            state_next = ST_RESP;
                        end else begin
                            cmd.op     = OP_INS_START;
                            cmd.rsp    = RSP_INSERTED;
                            state_next = ST_SIFT_UP;
                        end
                    end
                end
            end
            ST_POP_LOAD: begin
                // count is already decremented; nothing left means no sift
                cmd.op     = OP_POP_LOAD;
                state_next = sts.empty ? ST_RESP : ST_SIFT_DOWN;
            end
            ST_SIFT_UP: begin
                cmd.op = OP_UP_STEP;
                if (sts.up_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_SIFT_DOWN: begin
                cmd.op = OP_DOWN_STEP;
                if (sts.down_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/kwm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwm_datapath
    import kwm_pkg::*;
#(
    parameter int HEAP_SLOTS = HEAP_SLOTS_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  wire                        s_req_type,
    input  wire signed [VALUE_W-1:0]   s_element_value,
    input  wire [STREAM_W-1:0]         s_stream_id,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [1:0]                 m_status,
    output logic signed [VALUE_W-1:0]  m_out_value,
    output logic [STREAM_W-1:0]        m_out_stream,
    output logic                       m_now_empty
);

    localparam int IDX_W = $clog2(HEAP_SLOTS);
    localparam int CNT_W = $clog2(HEAP_SLOTS + 1);
    localparam int CHD_W = IDX_W + 2;

    // heap storage: one write port, two registered read ports
    entry_t mem [HEAP_SLOTS];
    entry_t rd_a_data_reg;
    entry_t rd_b_data_reg;
    logic [IDX_W-1:0] rd_a_addr;
    logic [IDX_W-1:0] rd_b_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] hole_reg;
    logic [IDX_W-1:0] hole_next;
    entry_t           key_reg;
    entry_t           key_next;
    rsp_t             res_status_reg;
    rsp_t             res_status_next;
    entry_t           res_entry_reg;
    entry_t           res_entry_next;

    logic             m_valid_reg;
    rsp_t             m_status_reg;
    entry_t           m_entry_reg;
    logic             m_now_empty_reg;

    logic [IDX_W-1:0] hole_m1;
    logic [IDX_W-1:0] parent;
    logic [CHD_W-1:0] left_idx;
    logic [CHD_W-1:0] right_idx;
    logic [CHD_W-1:0] count_ext;
    logic             left_ok;
    logic             right_ok;
    logic             pick_right;
    logic [CHD_W-1:0] best_idx;
    entry_t           best_data;
    logic             down_move;
    logic             up_move;
    logic [IDX_W:0]   nl_full;
    logic [IDX_W:0]   nr_full;
    logic [IDX_W-1:0] cnt_idx;
    logic [IDX_W-1:0] cnt_idx_m1;
    logic [CNT_W-1:0] count_m1;

    assign hole_m1    = hole_reg - 1'b1;
    assign parent     = hole_m1 >> 1;
    assign left_idx   = {1'b0, hole_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign count_ext  = CHD_W'(count_reg);
    assign left_ok    = left_idx < count_ext;
    assign right_ok   = right_idx < count_ext;
    assign pick_right = right_ok && key_less(rd_b_data_reg, rd_a_data_reg);
    assign best_idx   = pick_right ? right_idx : left_idx;
    assign best_data  = pick_right ? rd_b_data_reg : rd_a_data_reg;
    assign down_move  = left_ok && key_less(best_data, key_reg);
    assign up_move    = (hole_reg != '0) && key_less(key_reg, rd_a_data_reg);
    assign count_m1   = count_reg - 1'b1;
    assign cnt_idx    = count_reg[IDX_W-1:0];
    assign cnt_idx_m1 = cnt_idx - 1'b1;

    assign sts.in_pop    = (s_req_type == REQ_POP);
    assign sts.full      = (count_reg == CNT_W'(HEAP_SLOTS));
    assign sts.empty     = (count_reg == '0);
    assign sts.up_done   = !up_move;
    assign sts.down_done = !down_move;
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        count_next      = count_reg;
        hole_next       = hole_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        wr_en           = 1'b0;
        wr_addr         = hole_reg;
        wr_data         = key_reg;
        rd_a_addr       = '0;
        rd_b_addr       = '0;
        nl_full         = {hole_reg, 1'b1};
        nr_full         = nl_full + 1'b1;
        case (cmd.op)
            OP_REJECT: begin
                res_status_next = cmd.rsp;
                res_entry_next  = '0;
            end
            OP_INS_START: begin
                res_status_next = cmd.rsp;
                res_entry_next  = '0;
                key_next        = '{value: s_element_value, stream: s_stream_id};
                hole_next       = cnt_idx;
                count_next      = count_reg + 1'b1;
                rd_a_addr       = cnt_idx_m1 >> 1;
            end
            OP_POP_START: begin
                res_status_next = cmd.rsp;
                count_next      = count_m1;
                rd_a_addr       = '0;
                rd_b_addr       = count_m1[IDX_W-1:0];
            end
            OP_POP_LOAD: begin
                // root goes out, last element becomes the key to place from the top
                res_entry_next = rd_a_data_reg;
                key_next       = rd_b_data_reg;
                hole_next      = '0;
                nl_full        = {{IDX_W{1'b0}}, 1'b1};
                nr_full        = nl_full + 1'b1;
                rd_a_addr      = nl_full[IDX_W-1:0];
                rd_b_addr      = nr_full[IDX_W-1:0];
            end
            OP_UP_STEP: begin
                wr_en = 1'b1;
                if (up_move) begin
                    wr_data   = rd_a_data_reg;
                    hole_next = parent;
                    rd_a_addr = (parent - 1'b1) >> 1;
                end
            end
            OP_DOWN_STEP: begin
                wr_en = 1'b1;
                if (down_move) begin
                    wr_data   = best_data;
                    hole_next = best_idx[IDX_W-1:0];
                    nl_full   = {best_idx[IDX_W-1:0], 1'b1};
                    nr_full   = nl_full + 1'b1;
                    rd_a_addr = nl_full[IDX_W-1:0];
                    rd_b_addr = nr_full[IDX_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data_reg <= mem[rd_a_addr];
        rd_b_data_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hole_reg       <= hole_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        if (cmd.load_out) begin
            m_status_reg    <= res_status_reg;
            m_entry_reg     <= res_entry_reg;
            m_now_empty_reg <= (count_reg == '0);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_value  = m_entry_reg.value;
    assign m_out_stream = m_entry_reg.stream;
    assign m_now_empty  = m_now_empty_reg;

endmodule

`default_nettype wire

// ===== rtl/kwm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwm_checker
    import kwm_pkg::*;
(
    input wire                       aclk,
    input wire                       aresetn,
    input wire                       s_valid,
    input wire                       s_ready,
    input wire                       m_valid,
    input wire                       m_ready,
    input wire [1:0]                 m_status,
    input wire signed [VALUE_W-1:0]  m_out_value,
    input wire [STREAM_W-1:0]        m_out_stream,
    input wire                       m_now_empty
);

    // only a successful pop carries an element
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != RSP_POPPED) |-> (m_out_value == '0) && (m_out_stream == '0))
        else $error("non-pop result carries an element");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == RSP_EMPTY) |-> m_now_empty)
        else $error("empty pop reports a non-empty heap");

    a_nonempty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == RSP_INSERTED) || (m_status == RSP_FULL)) |-> !m_now_empty)
        else $error("insert or full result reports an empty heap");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_value)
            && $stable(m_out_stream) && $stable(m_now_empty))
        else $error("stalled result changed");

    // one request in flight at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

endmodule

bind k_way_merge_heap kwm_checker u_kwm_checker (.*);

`default_nettype wire
